>>> rtl/gdd_pkg.sv
// ----------------------------------------------------------------------------
// gdd_pkg: shared types, constants and calendar tables
// Types for the controller-to-datapath command and status, the sequencer
// state and step codes, and the Gregorian month tables.
// ----------------------------------------------------------------------------
`default_nettype none

package gdd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 22;
    localparam int DNUM_W   = 23;   // day number of any 14-bit year fits here
    localparam int PART_W   = 14;   // small terms of the day number
    localparam int MUL_A_W  = 15;   // year plus 399 still fits
    localparam int MUL_B_W  = 13;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int QUOT_W   = 9;    // year / 100 for any 15-bit operand

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for every x below 2**15.
    localparam logic [MUL_B_W-1:0] RECIP_100     = 13'd5243;
    localparam int                 RECIP_SHIFT   = 19;
    localparam logic [MUL_B_W-1:0] DAYS_PER_YEAR = 13'd365;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_Q0,
        ST_Q1,
        ST_Q2,
        ST_Q3,
        ST_SUM,
        ST_DONE
    } state_t;

    // Datapath step selected by the controller.
    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_Q0,
        STEP_Q1,
        STEP_Q2,
        STEP_Q3,
        STEP_SUM
    } step_t;

    typedef struct packed {
        logic  load;       // capture the input request
        step_t step;       // day number sequence step
        logic  date_sel;   // 0: start date, 1: end date
        logic  emit;       // write the result register
    } cmd_t;

    typedef struct packed {
        logic out_busy;    // result register holds an untaken result
    } status_t;

    // Length of a month; zero for a month code outside 1 to 12.
    function automatic logic [DAY_W-1:0] month_days(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] n;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = leap ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    // Days in the months before the given one in a common year.
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
        logic [8:0] n;
        case (month)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gdd_ctrl.sv
// ----------------------------------------------------------------------------
// gdd_ctrl: sequencer for the date difference unit
// Steps the datapath through the day number sequence for the start date and
// then the end date, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_ctrl
    import gdd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;

    // State and date select registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        in_ready     = 1'b0;
        cmd.load     = 1'b0;
        cmd.step     = STEP_NONE;
        cmd.date_sel = sel_reg;
        cmd.emit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    sel_next   = 1'b0;
                    state_next = ST_Q0;
                end
            end
            ST_Q0:
            begin
                cmd.step   = STEP_Q0;
                state_next = ST_Q1;
            end
            ST_Q1:
            begin
                cmd.step   = STEP_Q1;
                state_next = ST_Q2;
            end
            ST_Q2:
            begin
                cmd.step   = STEP_Q2;
                state_next = ST_Q3;
            end
            ST_Q3:
            begin
                cmd.step   = STEP_Q3;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.step = STEP_SUM;
                if (sel_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    sel_next   = 1'b1;
                    state_next = ST_Q0;
                end
            end
            ST_DONE:
            begin
                // Wait until the result register is free or being emptied.
                if (!status.out_busy || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/gdd_datapath.sv
// ----------------------------------------------------------------------------
// gdd_datapath: day number datapath for the date difference unit
// Holds the request, a shared multiplier for the year terms, the leap and
// validity checks, both day numbers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gdd_datapath
    import gdd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output status_t                 status,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    input  wire logic [YEAR_W-1:0]  start_year,
    input  wire logic [MONTH_W-1:0] start_month,
    input  wire logic [DAY_W-1:0]   start_day,
    input  wire logic [YEAR_W-1:0]  end_year,
    input  wire logic [MONTH_W-1:0] end_month,
    input  wire logic [DAY_W-1:0]   end_day,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [COUNT_W-1:0]      day_count,
    output logic                    date_error
);

    logic                include_end_day_reg;
    logic [YEAR_W-1:0]   sy_reg, ey_reg;
    logic [MONTH_W-1:0]  sm_reg, em_reg;
    logic [DAY_W-1:0]    sd_reg, ed_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                leap_reg;
    logic                err_reg;
    logic [6:0]          n400_reg;
    logic [PART_W-1:0]   part_reg;
    logic [DNUM_W-1:0]   dn_start_reg, dn_end_reg;
    logic                out_valid_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                error_reg;

    logic [YEAR_W-1:0]   y;
    logic [MONTH_W-1:0]  m;
    logic [DAY_W-1:0]    d;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [QUOT_W-1:0]   quot;
    logic [15:0]         quot_x100;
    logic                div100;
    logic                leap;
    logic [DAY_W-1:0]    mdays;
    logic                date_ok;
    logic [12:0]         y_div4;
    logic [PART_W-1:0]   part;
    logic [DNUM_W-1:0]   dnum;
    logic [DNUM_W-1:0]   diff;
    logic [DNUM_W:0]     total;
    logic [COUNT_W-1:0]  count;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            include_end_day_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            include_end_day_reg <= cfg_wr_data;
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sy_reg <= start_year;
            sm_reg <= start_month;
            sd_reg <= start_day;
            ey_reg <= end_year;
            em_reg <= end_month;
            ed_reg <= end_day;
        end
    end

    // Date under work.
    assign y = cmd.date_sel ? ey_reg : sy_reg;
    assign m = cmd.date_sel ? em_reg : sm_reg;
    assign d = cmd.date_sel ? ed_reg : sd_reg;

    // Shared multiplier operands: three divisions by 100, then the year times 365.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            STEP_Q0:
            begin
                mul_a = MUL_A_W'(y);
                mul_b = RECIP_100;
            end
            STEP_Q1:
            begin
                mul_a = MUL_A_W'(y) + MUL_A_W'(399);
                mul_b = RECIP_100;
            end
            STEP_Q2:
            begin
                mul_a = MUL_A_W'(y) + MUL_A_W'(99);
                mul_b = RECIP_100;
            end
            STEP_Q3:
            begin
                mul_a = MUL_A_W'(y);
                mul_b = DAYS_PER_YEAR;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Quotient of the previous division by 100.
    assign quot = prod_reg[PROD_W-1:RECIP_SHIFT];

    // Leap year: divisible by 4 and not by 100, or by 100 with a quotient divisible by 4.
    assign quot_x100 = {1'b0, quot, 6'b0} + {2'b0, quot, 5'b0} + {5'b0, quot, 2'b0};
    assign div100    = (quot_x100 == {2'b0, y});
    assign leap      = div100 ? (quot[1:0] == 2'b00) : (y[1:0] == 2'b00);

    // Date check with the leap flag of this year.
    assign mdays   = month_days(m, leap_reg);
    assign date_ok = (mdays != '0) && (d != '0) && (d <= mdays);

    // Small terms: (y+3)/4-(y+99)/100+(y+399)/400 + days before month + leap day + d - 1.
    assign y_div4 = 13'((MUL_A_W'(y) + MUL_A_W'(3)) >> 2);
    assign part   = PART_W'(y_div4) - PART_W'(quot) + PART_W'(n400_reg)
                  + PART_W'(days_before_month(m))
                  + PART_W'(leap_reg && (m > MONTH_FEB) && (m <= MONTH_DEC))
                  + PART_W'(d) - PART_W'(1);

    assign dnum = prod_reg[DNUM_W-1:0] + DNUM_W'(part_reg);

    // Sequence registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg <= 1'b0;
        end
        case (cmd.step)
            STEP_Q1:
            begin
                leap_reg <= leap;
            end
            STEP_Q2:
            begin
                n400_reg <= quot[QUOT_W-1:2];
                if (!date_ok)
                begin
                    err_reg <= 1'b1;
                end
            end
            STEP_Q3:
            begin
                part_reg <= part;
            end
            STEP_SUM:
            begin
                if (cmd.date_sel)
                begin
                    dn_end_reg <= dnum;
                end
                else
                begin
                    dn_start_reg <= dnum;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Difference, end day adjustment and saturation.
    assign diff  = (dn_start_reg < dn_end_reg) ? (dn_end_reg - dn_start_reg) : '0;
    assign total = {1'b0, diff} + (DNUM_W+1)'(include_end_day_reg);

    always_comb
    begin
        if (err_reg)
        begin
            count = '0;
        end
        else if (total > (DNUM_W+1)'(COUNT_MAX))
        begin
            count = COUNT_MAX;
        end
        else
        begin
            count = total[COUNT_W-1:0];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            count_reg <= count;
            error_reg <= err_reg;
        end
    end

    assign status.out_busy = out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign day_count       = count_reg;
    assign date_error      = error_reg;

endmodule

`default_nettype wire

>>> rtl/gregorian_date_difference_unit.sv
// ----------------------------------------------------------------------------
// gregorian_date_difference_unit: days between two Gregorian dates
// Top level: sequencer and day number datapath.
// ----------------------------------------------------------------------------
// Usage:
// A request carries a start and an end date (year, month, day) on the input
// channel (in_valid / in_ready). The result (day_count, date_error) appears
// on the output channel (out_valid / out_ready).
// Each date is turned into a day number in the steps Q0, Q1, Q2, Q3 and SUM
// on one shared multiplier (three divisions by 100 by reciprocal, then year
// times 365); the difference is formed combinationally from both day numbers
// and written to the output register. A new request is accepted the cycle
// after the result is written, so the block handles one request at a time.
// A finished result waits in its output register; if the receiver stalls,
// the next request still runs and holds in its last step until the output
// register is free.
// An invalid month or day sets date_error with a count of 0.
// include_end_day is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, as the block does not enforce this. Reset clears
// the sequencer, the output valid and include_end_day.
`default_nettype none

module gregorian_date_difference_unit
    import gdd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [YEAR_W-1:0]  start_year,
    input  wire logic [MONTH_W-1:0] start_month,
    input  wire logic [DAY_W-1:0]   start_day,
    input  wire logic [YEAR_W-1:0]  end_year,
    input  wire logic [MONTH_W-1:0] end_month,
    input  wire logic [DAY_W-1:0]   end_day,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [COUNT_W-1:0]      day_count,
    output logic                    date_error
);

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    gdd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath.
    gdd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .start_year  (start_year),
        .start_month (start_month),
        .start_day   (start_day),
        .end_year    (end_year),
        .end_month   (end_month),
        .end_day     (end_day),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .day_count   (day_count),
        .date_error  (date_error)
    );

endmodule

`default_nettype wire

>>> tb/gregorian_date_difference_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_difference_unit_tb: self-checking bench for the date unit
// Sends date pairs through the valid/ready input channel and checks every
// day count and error flag against a day-number predictor kept in the bench.
// The end-day option is switched between phases. Both sides idle at random,
// and the receiver once stalls long enough to back the block up.
// ----------------------------------------------------------------------------

module gregorian_date_difference_unit_tb;

    import gdd_pkg::*;

    localparam int RANDOM_PER_PHASE = 480;
    localparam int HOLD_AT          = 700;
    localparam int HOLD_CYCLES      = 400;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 40;
    localparam int MAX_REPORTS      = 40;
    localparam int YEAR_TOP         = (1 << YEAR_W) - 1;

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
    } date_request_t;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               date_error;
    } day_result_t;

    // Shapes of random date pairs.
    typedef enum logic [2:0] {
        PAIR_FREE,
        PAIR_NEAR,
        PAIR_SAME,
        PAIR_NOISE,
        PAIR_BROKEN
    } pair_kind_t;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic               cfg_wr_data = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [COUNT_W-1:0] day_count;
    logic               date_error;
    date_request_t      cur_req     = '0;

    date_request_t      pending_requests[$];
    day_result_t        expected_results[$];
    logic               end_day_model = 1'b0;
    int                 issued_cnt    = 0;
    int                 accepted_cnt  = 0;
    int                 checked_cnt   = 0;
    int                 error_count   = 0;
    int                 gap_left      = 0;
    int                 stall_left    = 0;
    int                 hold_left     = 0;
    int                 idle_cycles   = 0;

    gregorian_date_difference_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_year  (cur_req.start_year),
        .start_month (cur_req.start_month),
        .start_day   (cur_req.start_day),
        .end_year    (cur_req.end_year),
        .end_month   (cur_req.end_month),
        .end_day     (cur_req.end_day),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .day_count   (day_count),
        .date_error  (date_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    function automatic bit is_leap_year(input int y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    // Zero marks a month code outside 1 to 12.
    function automatic int month_length(input int m, input int y);
        int len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = is_leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic bit date_is_valid(input int y, input int m, input int d);
        int len;
        len = month_length(m, y);
        return len != 0 && d >= 1 && d <= len;
    endfunction

    // Days since 1 January of year 0.
    function automatic int day_index(input int y, input int m, input int d);
        int n;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (int k = 1; k < m; k++)
            n += month_length(k, y);
        return n + d - 1;
    endfunction

    function automatic day_result_t predict_day_count(input date_request_t r,
                                                      input logic include_end);
        day_result_t res;
        int          first_day;
        int          last_day;
        int          span;
        res = '0;
        if (!date_is_valid(r.start_year, r.start_month, r.start_day) ||
            !date_is_valid(r.end_year, r.end_month, r.end_day))
        begin
            res.date_error = 1'b1;
        end
        else
        begin
            first_day = day_index(r.start_year, r.start_month, r.start_day);
            last_day  = day_index(r.end_year, r.end_month, r.end_day);
            span      = (first_day < last_day) ? last_day - first_day : 0;
            span      = span + int'(include_end);
            if (span > int'(COUNT_MAX))
                span = int'(COUNT_MAX);
            res.day_count = COUNT_W'(span);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        if (error_count < MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    task automatic queue_request(input date_request_t r);
        pending_requests.push_back(r);
        issued_cnt++;
    endtask

    task automatic add_pair(input int sy, input int sm, input int sd,
                            input int ey, input int em, input int ed);
        date_request_t r;
        r.start_year  = YEAR_W'(sy);
        r.start_month = MONTH_W'(sm);
        r.start_day   = DAY_W'(sd);
        r.end_year    = YEAR_W'(ey);
        r.end_month   = MONTH_W'(em);
        r.end_day     = DAY_W'(ed);
        queue_request(r);
    endtask

    // Mostly ordinary years, some century years and some beyond 9999.
    task automatic pick_valid_date(input int y_fixed, output int y, output int m,
                                   output int d);
        int roll;
        int len;
        roll = $urandom_range(0, 9);
        if (y_fixed >= 0)
            y = y_fixed;
        else if (roll == 0)
            y = $urandom_range(0, YEAR_TOP);
        else if (roll == 1)
            y = $urandom_range(0, 163) * 100;
        else
            y = $urandom_range(0, 9999);
        m   = $urandom_range(1, 12);
        len = month_length(m, y);
        d   = ($urandom_range(0, 4) == 0) ? len : $urandom_range(1, len);
    endtask

    // Turns a valid month or day into an invalid one.
    task automatic corrupt_date(input int y, inout int m, inout int d);
        int len;
        int roll;
        roll = $urandom_range(0, 3);
        if ($urandom_range(0, 1) == 0)
        begin
            m = (roll == 0) ? 0 : 12 + roll;
        end
        else
        begin
            len = month_length(m, y);
            d = (len == 31 || roll < 2) ? 0 : $urandom_range(len + 1, 31);
        end
    endtask

    task automatic random_request(output date_request_t r);
        pair_kind_t kind;
        int         roll;
        int         sy, sm, sd, ey, em, ed;
        roll = $urandom_range(0, 99);
        kind = (roll < 55) ? PAIR_FREE :
               (roll < 70) ? PAIR_NEAR :
               (roll < 75) ? PAIR_SAME :
               (roll < 88) ? PAIR_NOISE : PAIR_BROKEN;
        pick_valid_date(-1, sy, sm, sd);
        case (kind)
            PAIR_NEAR:
            begin
                ey = sy + $urandom_range(0, 2);
                pick_valid_date((ey > YEAR_TOP) ? sy : ey, ey, em, ed);
            end
            PAIR_SAME:
            begin
                ey = sy;
                em = sm;
                ed = sd;
            end
            default:
                pick_valid_date(-1, ey, em, ed);
        endcase
        if (kind == PAIR_BROKEN)
        begin
            if ($urandom_range(0, 1) == 0)
                corrupt_date(sy, sm, sd);
            else
                corrupt_date(ey, em, ed);
        end
        r.start_year  = YEAR_W'(sy);
        r.start_month = MONTH_W'(sm);
        r.start_day   = DAY_W'(sd);
        r.end_year    = YEAR_W'(ey);
        r.end_month   = MONTH_W'(em);
        r.end_day     = DAY_W'(ed);
        // Noise covers every bit pattern of every field.
        if (kind == PAIR_NOISE)
            r = date_request_t'({$urandom, $urandom});
    endtask

    task automatic write_end_day_cfg(input logic value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        end_day_model = value;
        @(negedge clk);
    endtask

    // Counters change only at rising edges, so the falling edge sees a settled state.
    task automatic wait_until_drained();
        while (!(accepted_cnt == issued_cnt && checked_cnt == accepted_cnt))
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------

    initial
    begin
        date_request_t r;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        write_end_day_cfg(1'b0);

        // Directed corners: equal and reversed dates, range ends, leap rules,
        // saturation and invalid fields on either side.
        add_pair(2000, 1, 1, 2000, 1, 1);
        add_pair(2024, 3, 1, 2024, 2, 28);
        add_pair(0, 1, 1, YEAR_TOP, 12, 31);
        add_pair(0, 1, 1, 9999, 12, 31);
        add_pair(9999, 12, 31, 0, 1, 1);
        add_pair(2000, 2, 29, 2000, 3, 1);
        add_pair(1900, 2, 29, 1900, 3, 1);
        add_pair(2023, 2, 29, 2024, 2, 29);
        add_pair(2020, 2, 29, 2024, 2, 29);
        add_pair(0, 2, 29, 1, 1, 1);
        add_pair(2100, 2, 28, 2100, 3, 1);
        add_pair(1999, 12, 31, 2000, 1, 1);
        add_pair(2010, 0, 10, 2011, 5, 5);
        add_pair(2010, 5, 5, 2011, 13, 5);
        add_pair(2010, 15, 5, 2011, 15, 5);
        add_pair(2010, 5, 0, 2011, 5, 5);
        add_pair(2010, 4, 31, 2011, 12, 31);
        add_pair(2020, 1, 1, 2020, 6, 31);
        add_pair(YEAR_TOP, 15, 31, YEAR_TOP, 15, 31);
        add_pair(0, 0, 0, 0, 0, 0);
        add_pair(YEAR_TOP, 12, 31, YEAR_TOP, 12, 31);
        add_pair(YEAR_TOP, 1, 1, YEAR_TOP, 12, 31);
        add_pair(4, 2, 29, 4, 3, 1);
        wait_until_drained();

        // Random phases with the end-day option toggled between them.
        for (int p = 0; p < 3; p++)
        begin
            write_end_day_cfg((p % 2) == 0);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                random_request(r);
                queue_request(r);
            end
            wait_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding", 0, expected_results.size());

        if (error_count == 0)
            $display("gregorian_date_difference_unit regression: pass");
        else
            $display("gregorian_date_difference_unit regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------

    // Predicts each request as it is taken, then offers the next one after
    // a random gap, with stretches of back-to-back requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_day_count(cur_req, end_day_model));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    cur_req  <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                    gap_left <= ((accepted_cnt % 300) < 60) ? 0 : $urandom_range(0, 4);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------

    // Checks each result against the oldest prediction and draws the next
    // stall; once in the run it holds off long enough to fill the block.
    always @(posedge clk or negedge rst_n)
    begin
        day_result_t want;
        int          draw;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("result with no request pending", day_count, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (day_count !== want.day_count)
                    report_mismatch("day_count", day_count, want.day_count);
                if (date_error !== want.date_error)
                    report_mismatch("date_error", date_error, want.date_error);
            end
            checked_cnt <= checked_cnt + 1;
            if (checked_cnt + 1 == HOLD_AT)
            begin
                hold_left  <= HOLD_CYCLES;
                stall_left <= 0;
                out_ready  <= 1'b0;
            end
            else
            begin
                draw       = ((checked_cnt % 250) < 50) ? 0 : $urandom_range(0, 4);
                stall_left <= draw;
                out_ready  <= (draw == 0);
            end
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= (hold_left == 1);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------

    // Ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no request moved for %0d cycles", $time, idle_cycles);
            $display("gregorian_date_difference_unit regression: fail");
            $finish;
        end
    end

endmodule
